// ----- rtl/salru_pkg.sv -----
package salru_pkg;

    // Default sizes of the directory
    localparam int DEF_ADDR_BITS    = 32;
    localparam int DEF_MAX_SET_BITS = 10;
    localparam int DEF_MAX_WAYS     = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

    localparam logic [4:0] RST_OFFSET_BITS = 5'd4;
    localparam logic [3:0] RST_SET_BITS    = 4'd6;
    localparam logic [3:0] RST_WAYS        = 4'd1;

    // Way index and age fields sized for the largest supported associativity
    localparam int SCAN_IDX_W = 4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_UPDATE,
        ST_RESP
    } t_state;

    // Sequencer to scan unit
    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

    // Scan unit to sequencer
    typedef struct packed {
        logic                  hit;
        logic [SCAN_IDX_W-1:0] hit_way;
        logic [SCAN_IDX_W-1:0] hit_age;
        logic                  empty;
        logic [SCAN_IDX_W-1:0] empty_way;
        logic [SCAN_IDX_W-1:0] vic_way;
        logic [SCAN_IDX_W-1:0] vic_age;
    } t_scan_res;

endpackage

// ----- rtl/set_assoc_cache_lru_tags_unit.sv -----
// Channel    | Direction | Handshake                 | Word
// -----------+-----------+---------------------------+------------------------------------
// input      | in        | i_in_valid / o_in_ready   | i_address
// result     | out       | o_out_valid / i_out_ready | o_hit, o_access_number, o_hit_count
// config     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// From accept to result register one address passes a set row read, a pass over the
// ways in use, one way at a time, through the shared tag/age compare unit, and a row write.
// The result register holds a finished word while the next address is accepted.
// After reset a clearing pass writes every set row with o_in_ready low; configuration
// writes are taken throughout.
// A stalled result waits in the sequencer until the result register is free.
module set_assoc_cache_lru_tags_unit #(
    parameter int ADDR_BITS    = salru_pkg::DEF_ADDR_BITS,
    parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salru_pkg::DEF_MAX_WAYS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [31:0]                      i_address,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_hit,
    output logic [31:0]                      o_access_number,
    output logic [31:0]                      o_hit_count,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [salru_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [salru_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import salru_pkg::*;

    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAYC_W    = $clog2(MAX_WAYS + 1);
    localparam int AGE_W     = WAY_W;

    localparam logic [4:0]           MAX_SB   = 5'(MAX_SET_BITS);
    localparam logic [4:0]           MAX_NW   = 5'(MAX_WAYS);
    localparam logic [SET_IDX_W-1:0] LAST_SET = SET_IDX_W'(NUM_SETS - 1);

    // Sequencer and configuration
    t_state              r_state;
    t_state              n_state;
    logic [4:0]          r_offset_bits;
    logic [3:0]          r_set_bits;
    logic [3:0]          r_ways;
    logic [SET_IDX_W-1:0] r_clr;
    logic [WAY_W-1:0]    r_way;

    // Item under work
    logic [31:0]          r_addr;
    logic [SET_IDX_W-1:0] r_set;
    logic [ADDR_BITS-1:0] r_tag;

    // Counters and result register
    logic [31:0] r_acc_cnt;
    logic [31:0] r_hit_cnt;
    logic [31:0] n_acc_cnt;
    logic [31:0] n_hit_cnt;
    logic        r_out_valid;
    logic        r_out_hit;
    logic [31:0] r_out_acc;
    logic [31:0] r_out_hits;

    // Sequencer outputs
    logic      w_in_ready;
    logic      w_mem_re;
    logic      w_mem_we;
    logic      w_out_load;
    t_scan_ctl w_scan_ctl;
    t_scan_res w_res;

    // Address split
    logic [63:0]          w_addr_wide;
    logic [ADDR_BITS-1:0] w_addr;
    logic [4:0]           w_sb;
    logic [5:0]           w_sh;
    logic [SET_IDX_W-1:0] w_set_mask;
    logic [SET_IDX_W-1:0] w_set;
    logic [ADDR_BITS-1:0] w_tag;
    logic [4:0]           w_nway5;
    logic [WAYC_W-1:0]    w_nway;
    logic                 w_scan_last;
    logic                 w_slot_free;

    // Row read, update and write
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] w_rd_tag;
    logic [MAX_WAYS-1:0]                w_rd_valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0]     w_rd_age;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] w_new_tag;
    logic [MAX_WAYS-1:0]                w_new_valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0]     w_new_age;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] w_wr_tag;
    logic [MAX_WAYS-1:0]                w_wr_valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0]     w_wr_age;
    logic [SET_IDX_W-1:0]               w_waddr;
    logic [WAY_W-1:0]                   w_sel_way;
    logic [AGE_W:0]                     w_limit;

    // Split the address by the configured field sizes
    assign w_addr_wide = {32'b0, r_addr};
    assign w_addr      = w_addr_wide[ADDR_BITS-1:0];
    assign w_sb        = ({1'b0, r_set_bits} > MAX_SB) ? MAX_SB : {1'b0, r_set_bits};
    assign w_sh        = {1'b0, r_offset_bits} + {1'b0, w_sb};
    assign w_set_mask  = ~({SET_IDX_W{1'b1}} << w_sb);
    assign w_set       = SET_IDX_W'(w_addr >> r_offset_bits) & w_set_mask;
    assign w_tag       = w_addr >> w_sh;

    // Clamp the associativity in use
    assign w_nway5 = (r_ways == 4'd0) ? 5'd1 :
                     (({1'b0, r_ways} > MAX_NW) ? MAX_NW : {1'b0, r_ways});
    assign w_nway  = w_nway5[WAYC_W-1:0];

    assign w_scan_last = (WAYC_W'(r_way) == (w_nway - WAYC_W'(1)));
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (r_clr == LAST_SET) n_state = ST_IDLE;
            ST_IDLE:   if (i_in_valid) n_state = ST_LOOKUP;
            ST_LOOKUP: n_state = ST_SCAN;
            ST_SCAN:   if (w_scan_last) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_RESP;
            ST_RESP:   if (w_slot_free) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_in_ready       = 1'b0;
        w_mem_re         = 1'b0;
        w_mem_we         = 1'b0;
        w_out_load       = 1'b0;
        w_scan_ctl.clear = 1'b0;
        w_scan_ctl.step  = 1'b0;
        case (r_state)
            ST_CLEAR:  w_mem_we = 1'b1;
            ST_IDLE:   w_in_ready = 1'b1;
            ST_LOOKUP: begin
                w_mem_re         = 1'b1;
                w_scan_ctl.clear = 1'b1;
            end
            ST_SCAN:   w_scan_ctl.step = 1'b1;
            ST_UPDATE: w_mem_we = 1'b1;
            ST_RESP:   w_out_load = w_slot_free;
            default:   w_in_ready = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_offset_bits <= RST_OFFSET_BITS;
            r_set_bits    <= RST_SET_BITS;
            r_ways        <= RST_WAYS;
            r_clr         <= '0;
            r_way         <= '0;
            r_acc_cnt     <= '0;
            r_hit_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                    CFG_SET_BITS:    r_set_bits    <= i_cfg_data[3:0];
                    CFG_WAYS:        r_ways        <= i_cfg_data[3:0];
                    default:         r_ways        <= r_ways;
                endcase
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + SET_IDX_W'(1);
            end
            if (w_scan_ctl.clear) begin
                r_way <= '0;
            end else if (w_scan_ctl.step) begin
                r_way <= r_way + WAY_W'(1);
            end
            if (w_out_load) begin
                r_acc_cnt   <= n_acc_cnt;
                r_hit_cnt   <= n_hit_cnt;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign n_acc_cnt = r_acc_cnt + 32'd1;
    assign n_hit_cnt = r_hit_cnt + {31'b0, w_res.hit};

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in_valid) begin
            r_addr <= i_address;
        end
        if (r_state == ST_LOOKUP) begin
            r_set <= w_set;
            r_tag <= w_tag;
        end
        if (w_out_load) begin
            r_out_hit  <= w_res.hit;
            r_out_acc  <= n_acc_cnt;
            r_out_hits <= n_hit_cnt;
        end
    end

    salru_row_mem #(
        .ADDR_BITS    (ADDR_BITS),
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .SET_IDX_W    (SET_IDX_W),
        .AGE_W        (AGE_W)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (w_mem_we),
        .i_waddr  (w_waddr),
        .i_wtag   (w_wr_tag),
        .i_wvalid (w_wr_valid),
        .i_wage   (w_wr_age),
        .i_re     (w_mem_re),
        .i_raddr  (w_set),
        .o_rtag   (w_rd_tag),
        .o_rvalid (w_rd_valid),
        .o_rage   (w_rd_age)
    );

    salru_way_scan #(
        .ADDR_BITS (ADDR_BITS),
        .MAX_WAYS  (MAX_WAYS),
        .WAY_W     (WAY_W),
        .AGE_W     (AGE_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_scan_ctl),
        .i_way       (r_way),
        .i_key       (r_tag),
        .i_ent_tag   (w_rd_tag[r_way]),
        .i_ent_valid (w_rd_valid[r_way]),
        .i_ent_age   (w_rd_age[r_way]),
        .o_res       (w_res)
    );

    // Pick the way to touch and the age bound for the others
    always_comb begin
        if (w_res.hit) begin
            w_sel_way = w_res.hit_way[WAY_W-1:0];
            w_limit   = {1'b0, w_res.hit_age[AGE_W-1:0]};
        end else if (w_res.empty) begin
            w_sel_way = w_res.empty_way[WAY_W-1:0];
            w_limit   = {1'b1, {AGE_W{1'b0}}};
        end else begin
            w_sel_way = w_res.vic_way[WAY_W-1:0];
            w_limit   = {1'b0, w_res.vic_age[AGE_W-1:0]};
        end
    end

    // Age the younger ways in use, make the touched way most recent
    always_comb begin
        w_new_tag   = w_rd_tag;
        w_new_valid = w_rd_valid;
        w_new_age   = w_rd_age;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if ((WAYC_W'(w) < w_nway) && w_rd_valid[w]
                && ({1'b0, w_rd_age[w]} < w_limit)) begin
                w_new_age[w] = w_rd_age[w] + AGE_W'(1);
            end
        end
        w_new_tag[w_sel_way]   = r_tag;
        w_new_valid[w_sel_way] = 1'b1;
        w_new_age[w_sel_way]   = '0;
    end

    // Clear rows after reset, otherwise write back the updated row
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_waddr    = r_clr;
            w_wr_tag   = '0;
            w_wr_valid = '0;
            w_wr_age   = '0;
        end else begin
            w_waddr    = r_set;
            w_wr_tag   = w_new_tag;
            w_wr_valid = w_new_valid;
            w_wr_age   = w_new_age;
        end
    end

    assign o_in_ready      = w_in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_access_number = r_out_acc;
    assign o_hit_count     = r_out_hits;
    assign o_cfg_ready     = 1'b1;

endmodule

// ----- rtl/salru_row_mem.sv -----
module salru_row_mem #(
    parameter int ADDR_BITS    = salru_pkg::DEF_ADDR_BITS,
    parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salru_pkg::DEF_MAX_WAYS,
    parameter int SET_IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    parameter int AGE_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [SET_IDX_W-1:0]                i_waddr,
    input  logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  i_wtag,
    input  logic [MAX_WAYS-1:0]                 i_wvalid,
    input  logic [MAX_WAYS-1:0][AGE_W-1:0]      i_wage,
    input  logic                                i_re,
    input  logic [SET_IDX_W-1:0]                i_raddr,
    output logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  o_rtag,
    output logic [MAX_WAYS-1:0]                 o_rvalid,
    output logic [MAX_WAYS-1:0][AGE_W-1:0]      o_rage
);
    import salru_pkg::*;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;

    // One row per set: tags, valid bits and LRU ages of all ways
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] r_tag_mem   [NUM_SETS];
    logic [MAX_WAYS-1:0]                r_valid_mem [NUM_SETS];
    logic [MAX_WAYS-1:0][AGE_W-1:0]     r_age_mem   [NUM_SETS];

    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] r_rtag;
    logic [MAX_WAYS-1:0]                r_rvalid;
    logic [MAX_WAYS-1:0][AGE_W-1:0]     r_rage;

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_tag_mem[i_waddr]   <= i_wtag;
            r_valid_mem[i_waddr] <= i_wvalid;
            r_age_mem[i_waddr]   <= i_wage;
        end
    end

    // Read one row, hold it until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rtag   <= r_tag_mem[i_raddr];
            r_rvalid <= r_valid_mem[i_raddr];
            r_rage   <= r_age_mem[i_raddr];
        end
    end

    assign o_rtag   = r_rtag;
    assign o_rvalid = r_rvalid;
    assign o_rage   = r_rage;

endmodule

// ----- rtl/salru_way_scan.sv -----
module salru_way_scan #(
    parameter int ADDR_BITS = salru_pkg::DEF_ADDR_BITS,
    parameter int MAX_WAYS  = salru_pkg::DEF_MAX_WAYS,
    parameter int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    parameter int AGE_W     = WAY_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  salru_pkg::t_scan_ctl  i_ctl,
    input  logic [WAY_W-1:0]      i_way,
    input  logic [ADDR_BITS-1:0]  i_key,
    input  logic [ADDR_BITS-1:0]  i_ent_tag,
    input  logic                  i_ent_valid,
    input  logic [AGE_W-1:0]      i_ent_age,
    output salru_pkg::t_scan_res  o_res
);
    import salru_pkg::*;

    t_scan_res             r_res;
    logic                  w_match;
    logic                  w_older;
    logic [SCAN_IDX_W-1:0] w_way;
    logic [SCAN_IDX_W-1:0] w_age;

    // Shared compare unit: one tag compare and one age compare per way
    assign w_way   = SCAN_IDX_W'(i_way);
    assign w_age   = SCAN_IDX_W'(i_ent_age);
    assign w_match = i_ent_valid && (i_ent_tag == i_key);
    assign w_older = (i_way == '0) || (w_age > r_res.vic_age);

    // Accumulate first hit, first empty way and oldest way
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.hit   <= 1'b0;
            r_res.empty <= 1'b0;
        end else if (i_ctl.clear) begin
            r_res.hit   <= 1'b0;
            r_res.empty <= 1'b0;
        end else if (i_ctl.step) begin
            if (w_match && !r_res.hit) begin
                r_res.hit     <= 1'b1;
                r_res.hit_way <= w_way;
                r_res.hit_age <= w_age;
            end
            if (!i_ent_valid && !r_res.empty) begin
                r_res.empty     <= 1'b1;
                r_res.empty_way <= w_way;
            end
            if (w_older) begin
                r_res.vic_way <= w_way;
                r_res.vic_age <= w_age;
            end
        end
    end

    assign o_res = r_res;

endmodule

// ----- rtl/salru_checker.sv -----
module salru_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_hit,
    input logic [31:0] o_access_number,
    input logic [31:0] o_hit_count
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_hit) && $stable(o_access_number)
             && $stable(o_hit_count)))
        else $error("result word changed while stalled");

    // Drop ready as soon as an address is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted address");

    // A new result word appears only as the sequencer returns to idle
    a_result_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result word loaded while the sequencer is busy");

    // Consecutive words advance the access count by one and the hit count by the hit
    a_counts_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && $past(o_out_valid && i_out_ready)
         && (o_access_number != $past(o_access_number))) |->
            ((o_access_number == $past(o_access_number) + 32'd1)
             && (o_hit_count == $past(o_hit_count) + {31'b0, o_hit})))
        else $error("access or hit count stepped wrongly");

endmodule

bind set_assoc_cache_lru_tags_unit salru_checker u_salru_checker (.*);

// ----- sim/tb_set_assoc_cache_lru_tags_unit.sv -----
module tb_set_assoc_cache_lru_tags_unit;
    import salru_pkg::*;

    localparam int SET_CAP     = 1 << DEF_MAX_SET_BITS;
    localparam int WAY_CAP     = DEF_MAX_WAYS;
    localparam int SETTLE      = DEF_MAX_WAYS + 8;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 95;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Geometry of the fixed random phases: offset bits, set bits, ways
    localparam logic [4:0] PHASE_OFF  [10] = '{5'd4, 5'd0, 5'd16, 5'd31, 5'd5,
                                              5'd2, 5'd12, 5'd6, 5'd3, 5'd0};
    localparam logic [4:0] PHASE_SETS [10] = '{5'd6, 5'd0, 5'd10, 5'd15, 5'd3,
                                              5'd10, 5'd0, 5'd8, 5'd2, 5'd10};
    localparam logic [4:0] PHASE_WAYS [10] = '{5'd1, 5'd8, 5'd8, 5'd15, 5'd4,
                                              5'd2, 5'd0, 5'd8, 5'd3, 5'd8};

    typedef struct packed {
        logic        hit;
        logic [31:0] access_number;
        logic [31:0] hit_count;
    } t_access_word;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [31:0]           i_address   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_hit;
    logic [31:0]           o_access_number;
    logic [31:0]           o_hit_count;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Shadow directory and settings
    logic [63:0] dir_tag   [SET_CAP*WAY_CAP];
    bit          dir_valid [SET_CAP*WAY_CAP];
    int          dir_age   [SET_CAP*WAY_CAP];
    logic [4:0]  cur_offset;
    logic [3:0]  cur_sets;
    logic [3:0]  cur_ways;
    logic [31:0] access_total = '0;
    logic [31:0] hit_total    = '0;

    t_access_word pending_results[$];

    int          err_count   = 0;
    int          quiet_cycles = 0;
    int          in_gap      = 0;
    int          out_wait    = 0;
    bit          in_held     = 1'b0;
    bit          no_idle     = 1'b0;
    logic [31:0] tag_base    = '0;
    int          set_base    = 0;

    set_assoc_cache_lru_tags_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_address       (i_address),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_hit           (o_hit),
        .o_access_number (o_access_number),
        .o_hit_count     (o_hit_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int used_set_bits();
        return (cur_sets > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(cur_sets);
    endfunction

    function automatic int used_ways();
        if (cur_ways == 0)
            return 1;
        return (cur_ways > WAY_CAP) ? WAY_CAP : int'(cur_ways);
    endfunction

    // Bump every valid way younger than the limit
    function automatic void age_below(int base, int nway, int limit);
        for (int w = 0; w < nway; w++) begin
            if (dir_valid[base+w] && dir_age[base+w] < limit && dir_age[base+w] < 255)
                dir_age[base+w]++;
        end
    endfunction

    // Look up one address, update LRU state and queue the expected word
    function automatic void predict_access(logic [31:0] addr);
        int           sb;
        int           nway;
        int           sh;
        int           base;
        int           found;
        int           victim;
        logic [63:0]  tag;
        bit           hit;
        bit           empty;
        t_access_word word;
        sb    = used_set_bits();
        nway  = used_ways();
        sh    = int'(cur_offset) + sb;
        base  = int'((64'(addr) >> cur_offset) & ((64'd1 << sb) - 64'd1)) * WAY_CAP;
        tag   = (sh >= 64) ? 64'd0 : (64'(addr) >> sh);
        hit   = 1'b0;
        found = base;
        for (int w = 0; w < nway; w++) begin
            if (!hit && dir_valid[base+w] && dir_tag[base+w] == tag) begin
                hit   = 1'b1;
                found = base + w;
            end
        end
        if (hit) begin
            age_below(base, nway, dir_age[found]);
            dir_age[found] = 0;
        end else begin
            empty  = 1'b0;
            victim = base;
            for (int w = 0; w < nway; w++) begin
                if (!empty && !dir_valid[base+w]) begin
                    empty  = 1'b1;
                    victim = base + w;
                end
            end
            if (empty) begin
                age_below(base, nway, 256);
            end else begin
                // evict the oldest, lowest way on a tie
                for (int w = 1; w < nway; w++)
                    if (dir_age[base+w] > dir_age[victim])
                        victim = base + w;
                age_below(base, nway, dir_age[victim]);
            end
            dir_tag[victim]   = tag;
            dir_valid[victim] = 1'b1;
            dir_age[victim]   = 0;
        end
        access_total++;
        if (hit)
            hit_total++;
        word.hit           = hit;
        word.access_number = access_total;
        word.hit_count     = hit_total;
        pending_results.insert(pending_results.size(), word);
    endfunction

    // Build an address from tag, set and byte offset under the current geometry
    function automatic logic [31:0] compose(logic [31:0] tag, int set_idx, logic [31:0] byte_off);
        int          sb;
        int          sh;
        logic [63:0] a;
        sb = used_set_bits();
        sh = int'(cur_offset) + sb;
        a  = 64'(byte_off) & ((64'd1 << cur_offset) - 64'd1);
        a |= (64'(set_idx) & ((64'd1 << sb) - 64'd1)) << cur_offset;
        if (sh < 64)
            a |= 64'(tag) << sh;
        return a[31:0];
    endfunction

    // Mostly reuse a small pool of blocks, sometimes a wild address
    function automatic logic [31:0] pick_address();
        if ($urandom_range(0, 99) < 15)
            return $urandom();
        return compose(tag_base + $urandom_range(0, used_ways() + 1),
                       set_base + $urandom_range(0, 3), $urandom());
    endfunction

    // Send one address word; hold valid high when the next word follows at once
    task automatic send_address(input logic [31:0] addr);
        if (!in_held)
            repeat (in_gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_address  <= addr;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predict_access(addr);
        in_gap  = no_idle ? 0 : $urandom_range(0, 6);
        in_held = (in_gap == 0);
        if (!in_held)
            i_in_valid <= 1'b0;
    endtask

    // Drop valid, drain every expected word and let the pipeline settle
    task automatic wait_idle();
        if (in_held) begin
            i_in_valid <= 1'b0;
            in_held = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        repeat ($urandom_range(0, 6)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_OFFSET_BITS: cur_offset = data[4:0];
            CFG_SET_BITS:    cur_sets   = data[3:0];
            CFG_WAYS:        cur_ways   = data[3:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input logic [4:0] off, input logic [4:0] sets,
                                input logic [4:0] nway);
        write_reg(CFG_OFFSET_BITS, off);
        write_reg(CFG_SET_BITS, sets);
        write_reg(CFG_WAYS, nway);
    endtask

    // Reset geometry: one way, hit within a block, conflict eviction
    task automatic test_reset_geometry();
        send_address(32'h0000_0000);
        send_address(32'h0000_000F);
        send_address(32'hFFFF_FFFF);
        send_address(compose(32'd1, 0, 32'd0));
        send_address(32'h0000_0000);
    endtask

    // Four ways: fill a set, touch the oldest, then check who gets evicted
    task automatic test_lru_order();
        set_geometry(5'd4, 5'd2, 5'd4);
        for (int t = 1; t <= 4; t++)
            send_address(compose(t, 1, 32'd0));
        send_address(compose(32'd1, 1, 32'd7));
        send_address(compose(32'd5, 1, 32'd0));
        send_address(compose(32'd2, 1, 32'd0));
        send_address(compose(32'd1, 1, 32'd0));
    endtask

    // Oversized and zero settings, plus a write to an unused register
    task automatic test_config_limits();
        set_geometry(5'd31, 5'h1F, 5'd15);
        send_address(32'hFFFF_FFFF);
        send_address(32'h8000_0000);
        send_address(32'h7FFF_FFFF);
        set_geometry(5'd0, 5'd0, 5'd0);
        send_address(32'h0000_0000);
        send_address(32'h0000_0000);
        send_address(32'hFFFF_FFFF);
        write_reg(CFG_SPARE, 5'h1F);
        write_reg(CFG_WAYS, 5'h11);
        send_address(32'hFFFF_FFFF);
    endtask

    // Ways above a lowered associativity keep their tags until it grows back
    task automatic test_narrowed_ways();
        set_geometry(5'd4, 5'd1, 5'd8);
        for (int t = 1; t <= 3; t++)
            send_address(compose(t, 0, 32'd0));
        write_reg(CFG_WAYS, 5'd1);
        send_address(compose(32'd3, 0, 32'd0));
        write_reg(CFG_WAYS, 5'd8);
        send_address(compose(32'd3, 0, 32'd0));
        send_address(compose(32'd2, 0, 32'd0));
        send_address(compose(32'd1, 0, 32'd0));
    endtask

    // Reuse-heavy traffic over fixed and random geometries
    task automatic test_random_traffic();
        for (int p = 0; p < 12; p++) begin
            if (p < 10)
                set_geometry(PHASE_OFF[p], PHASE_SETS[p], PHASE_WAYS[p]);
            else
                set_geometry(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                             5'($urandom_range(0, 31)));
            tag_base = $urandom();
            set_base = $urandom_range(0, SET_CAP - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 20 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                send_address(pick_address());
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stalls, compare each word with the oldest expectation
    always @(posedge i_clk) begin : result_side
        t_access_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected word hit=%0b access=%0d hits=%0d",
                             $time, o_hit, o_access_number, o_hit_count);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_hit !== want.hit) begin
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit, o_hit);
                        err_count++;
                    end
                    if (o_access_number !== want.access_number) begin
                        $display("%0t: access_number expected %0d actual %0d",
                                 $time, want.access_number, o_access_number);
                        err_count++;
                    end
                    if (o_hit_count !== want.hit_count) begin
                        $display("%0t: hit_count expected %0d actual %0d",
                                 $time, want.hit_count, o_hit_count);
                        err_count++;
                    end
                end
                out_wait = no_idle ? 0 : $urandom_range(0, 6);
            end else if (out_wait > 0) begin
                out_wait--;
            end
            i_out_ready <= (out_wait == 0);
        end
    end

    // Watchdog: end the run after too long without any handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_set_assoc_cache_lru_tags_unit: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int e = 0; e < SET_CAP * WAY_CAP; e++) begin
            dir_tag[e]   = '0;
            dir_valid[e] = 1'b0;
            dir_age[e]   = 0;
        end
        cur_offset = RST_OFFSET_BITS;
        cur_sets   = RST_SET_BITS;
        cur_ways   = RST_WAYS;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_geometry();
        test_lru_order();
        test_config_limits();
        test_narrowed_ways();
        test_random_traffic();
        wait_idle();
        if (err_count == 0)
            $display("tb_set_assoc_cache_lru_tags_unit: clean");
        else
            $display("tb_set_assoc_cache_lru_tags_unit: errors");
        $finish;
    end

endmodule
